@@ rtl/core/tdt_pkg.sv @@
// Package for the task dependency tracker.
// Holds sizes, request codes and the controller state type; no dependencies.
package tdt_pkg;

    localparam int MAX_TASKS  = 32;
    localparam int MAX_EDGES  = 256;
    localparam int ID_W       = 5;
    localparam int EADDR_W    = $clog2(MAX_EDGES);
    localparam int ECNT_W     = EADDR_W + 1;
    localparam int CNT_W      = 9;
    localparam int TIDX_W     = ID_W + 1;

    typedef enum logic [2:0] {
        REQ_ADD_TASK = 3'd0,
        REQ_ADD_EDGE = 3'd1,
        REQ_COMPLETE = 3'd2,
        REQ_LIST     = 3'd3,
        REQ_CYCLE    = 3'd4,
        REQ_QUERY    = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage

@@ rtl/core/task_dependency_tracker.sv @@
// Top level of the task dependency tracker.
// Depends on tdt_pkg; the edge store is a memory inside this module.
//
// Usage:
// The request channel (in_valid/in_ready) carries req_type, task_id and
// depends_on_id. The result channel (out_valid/out_ready) returns one or
// more items per request; the final item of a request has last set.
// One request is worked on at a time; in_ready is high only while idle,
// but a new request is taken while the last result still waits.
// For add task, add edge, list ready and query the request passes through
// the emit state into the output register. Complete of a task not yet done
// first walks the edge store, one read of the edge store per cycle, then
// hands out the ready tasks one per cycle while the receiver does not stall.
// The cycle check scans the 32 task slots once per pass and walks the edge
// store for every task it visits; at most 33 passes.
// Reset clears counts, task flags and the edge count; edge store contents
// need no clearing. When the receiver stalls, the result is held in the
// output register and the tracker waits; no item is lost.
module task_dependency_tracker
    import tdt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic [ID_W-1:0]   task_id,
    input  logic [ID_W-1:0]   depends_on_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   ready_task_id,
    output logic              ready_valid,
    output logic              last,
    output logic              has_cycle,
    output logic              is_done,
    output logic              status
);

    // Edge store: prerequisite in the upper bits, dependent in the lower.
    logic [2*ID_W-1:0] edge_mem [MAX_EDGES];
    logic [2*ID_W-1:0] rd_data_reg;
    logic [EADDR_W-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [ECNT_W-1:0] edge_cnt_reg;
    logic [CNT_W-1:0]  base_reg [MAX_TASKS];
    logic [CNT_W-1:0]  rem_reg [MAX_TASKS];
    logic [CNT_W-1:0]  scr_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0] present_reg, done_reg, visit_reg;
    logic [MAX_TASKS-1:0] mask_reg;
    logic [ECNT_W-1:0] e_reg;
    logic              vld_reg;
    logic              cc_reg;
    logic              prog_reg;
    logic [ID_W-1:0]   node_reg;
    logic [TIDX_W-1:0] t_reg;
    logic              f_cyc_reg, f_done_reg, f_st_reg;

    logic              out_valid_reg;
    logic [ID_W-1:0]   o_id_reg;
    logic              o_rv_reg, o_last_reg, o_cyc_reg, o_done_reg, o_st_reg;

    logic              accept;
    logic              out_free;
    logic [ID_W-1:0]   low_idx;
    logic [MAX_TASKS-1:0] ready_mask;
    logic [ID_W-1:0]   dep_id, tk_id;
    logic              walk_end;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign rd_addr  = e_reg[EADDR_W-1:0];
    assign dep_id   = rd_data_reg[2*ID_W-1:ID_W];
    assign tk_id    = rd_data_reg[ID_W-1:0];
    assign walk_end = (e_reg >= edge_cnt_reg) && !vld_reg;

    // Lowest set bit of the pending ready mask.
    always_comb
    begin
        low_idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                low_idx = ID_W'(i);
        end
    end

    // Tasks present, fully satisfied and not done.
    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
            ready_mask[i] = present_reg[i] && (rem_reg[i] == '0) && !done_reg[i];
    end

    // Edge store write on add edge and registered read during walks.
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_ADD_EDGE && edge_cnt_reg < ECNT_W'(MAX_EDGES))
            edge_mem[edge_cnt_reg[EADDR_W-1:0]] <= {depends_on_id, task_id};
        rd_data_reg <= edge_mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_COMPLETE && !done_reg[task_id])
                        state_next = S_WALK;
                    else if (req_type == REQ_CYCLE)
                        state_next = S_SCAN;
                    else
                        state_next = S_EMIT;
                end
            end
            S_WALK:
            begin
                if (walk_end)
                    state_next = cc_reg ? S_SCAN : S_EMIT;
            end
            S_SCAN:
            begin
                if (t_reg == TIDX_W'(MAX_TASKS))
                begin
                    if (!prog_reg)
                        state_next = S_EMIT;
                end
                else if (present_reg[t_reg[ID_W-1:0]] && !visit_reg[t_reg[ID_W-1:0]]
                         && scr_reg[t_reg[ID_W-1:0]] == '0)
                    state_next = S_WALK;
            end
            S_EMIT:
            begin
                if (out_free && (mask_reg == '0 || (mask_reg & ~(1 << low_idx)) == '0))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and task state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            edge_cnt_reg <= '0;
            present_reg  <= '0;
            done_reg     <= '0;
            visit_reg    <= '0;
            mask_reg     <= '0;
            e_reg        <= '0;
            vld_reg      <= 1'b0;
            cc_reg       <= 1'b0;
            prog_reg     <= 1'b0;
            node_reg     <= '0;
            t_reg        <= '0;
            f_cyc_reg    <= 1'b0;
            f_done_reg   <= 1'b0;
            f_st_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                base_reg[i] <= '0;
                rem_reg[i]  <= '0;
                scr_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                // Take a request and do the work that needs no walk or scan.
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mask_reg   <= (req_type == REQ_LIST) ? ready_mask : '0;
                        f_cyc_reg  <= 1'b0;
                        f_done_reg <= (req_type == REQ_QUERY) && done_reg[task_id];
                        f_st_reg   <= (req_type == REQ_ADD_EDGE)
                                      && (edge_cnt_reg >= ECNT_W'(MAX_EDGES));
                        e_reg      <= '0;
                        vld_reg    <= 1'b0;
                        node_reg   <= task_id;
                        t_reg      <= '0;
                        prog_reg   <= 1'b0;
                        case (req_type)
                            REQ_ADD_TASK: present_reg[task_id] <= 1'b1;
                            REQ_ADD_EDGE:
                            begin
                                present_reg <= present_reg
                                               | (MAX_TASKS'(1) << task_id)
                                               | (MAX_TASKS'(1) << depends_on_id);
                                if (edge_cnt_reg < ECNT_W'(MAX_EDGES))
                                begin
                                    edge_cnt_reg      <= edge_cnt_reg + 1'b1;
                                    base_reg[task_id] <= base_reg[task_id] + 1'b1;
                                    rem_reg[task_id]  <= rem_reg[task_id] + 1'b1;
                                end
                            end
                            REQ_COMPLETE:
                            begin
                                done_reg[task_id] <= 1'b1;
                                cc_reg            <= 1'b0;
                            end
                            REQ_CYCLE:
                            begin
                                cc_reg    <= 1'b1;
                                visit_reg <= '0;
                                for (int i = 0; i < MAX_TASKS; i++)
                                    scr_reg[i] <= base_reg[i];
                            end
                            default: ;
                        endcase
                    end
                end
                // Walk the edge store, one read per cycle.
                S_WALK:
                begin
                    if (e_reg < edge_cnt_reg)
                    begin
                        e_reg   <= e_reg + 1'b1;
                        vld_reg <= 1'b1;
                    end
                    else
                        vld_reg <= 1'b0;
                    if (vld_reg && dep_id == node_reg)
                    begin
                        if (cc_reg)
                        begin
                            if (scr_reg[tk_id] != '0)
                                scr_reg[tk_id] <= scr_reg[tk_id] - 1'b1;
                        end
                        else if (rem_reg[tk_id] != '0)
                        begin
                            rem_reg[tk_id] <= rem_reg[tk_id] - 1'b1;
                            if (rem_reg[tk_id] == CNT_W'(1) && !done_reg[tk_id])
                                mask_reg[tk_id] <= 1'b1;
                        end
                    end
                end
                // Kahn pass over the task slots.
                S_SCAN:
                begin
                    e_reg   <= '0;
                    vld_reg <= 1'b0;
                    if (t_reg == TIDX_W'(MAX_TASKS))
                    begin
                        t_reg    <= '0;
                        prog_reg <= 1'b0;
                        if (!prog_reg)
                            f_cyc_reg <= (visit_reg != present_reg);
                    end
                    else
                    begin
                        t_reg <= t_reg + 1'b1;
                        if (present_reg[t_reg[ID_W-1:0]] && !visit_reg[t_reg[ID_W-1:0]]
                            && scr_reg[t_reg[ID_W-1:0]] == '0)
                        begin
                            visit_reg[t_reg[ID_W-1:0]] <= 1'b1;
                            prog_reg <= 1'b1;
                            node_reg <= t_reg[ID_W-1:0];
                        end
                    end
                end
                // Hand results to the output register.
                S_EMIT:
                begin
                    if (out_free && mask_reg != '0)
                        mask_reg[low_idx] <= 1'b0;
                end
                default: ;
            endcase

            // Output register: load in the emit state, clear after the transfer.
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && out_free)
        begin
            if (mask_reg == '0)
            begin
                o_id_reg   <= '0;
                o_rv_reg   <= 1'b0;
                o_last_reg <= 1'b1;
                o_cyc_reg  <= f_cyc_reg;
                o_done_reg <= f_done_reg;
                o_st_reg   <= f_st_reg;
            end
            else
            begin
                o_id_reg   <= low_idx;
                o_rv_reg   <= 1'b1;
                o_last_reg <= ((mask_reg & ~(1 << low_idx)) == '0);
                o_cyc_reg  <= 1'b0;
                o_done_reg <= 1'b0;
                o_st_reg   <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign ready_task_id = o_id_reg;
    assign ready_valid   = o_rv_reg;
    assign last          = o_last_reg;
    assign has_cycle     = o_cyc_reg;
    assign is_done       = o_done_reg;
    assign status        = o_st_reg;

endmodule
